// ===== src/led_grayscale_frame_packer_assert.svh =====
// assertion macros for the checker file
`ifndef LED_GRAYSCALE_FRAME_PACKER_ASSERT_SVH
`define LED_GRAYSCALE_FRAME_PACKER_ASSERT_SVH

// clocked assertion, off while reset is held
`define LGFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define LGFP_IMPLY(lbl, ante, cons, msg) \
  `LGFP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== src/lgfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lgfp_pkg;

  localparam int unsigned LEVEL_W       = 12;
  localparam int unsigned CHAN_W        = 7;
  localparam int unsigned CHANS_PER_DRV = 24;
  localparam int unsigned WORD_W        = 2 * LEVEL_W;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_SET_ALL = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr_one;      // write one channel from the input
    logic wr_all;      // write every channel from the input
    logic rd_chan;     // read the row of the input channel
    logic rd_row;      // read the row the controller names
    logic load_reply;  // load a read reply into the output register
    logic load_frame;  // load a frame word into the output register
    logic frame_last;  // frame word being loaded is the final one
  } ctrl_t;

  typedef struct packed {
    logic out_free;    // output register can take a new word this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== src/lgfp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgfp_ctrl #(
  parameter int unsigned NUM_DRIVERS = 1
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            in_cmd_i,
  input  wire lgfp_pkg::status_t                     status_i,
  output lgfp_pkg::ctrl_t                            ctrl_o,
  output logic [$clog2(NUM_DRIVERS * 12)-1:0]        row_o
);
  import lgfp_pkg::*;

  localparam int unsigned ROWS  = NUM_DRIVERS * (CHANS_PER_DRV / 2);
  localparam int unsigned ROW_W = $clog2(ROWS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FRAME
  } state_e;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] iss_row_q, iss_row_d;
  logic             iss_done_q, iss_done_d;
  logic             pend_q, pend_d;
  logic [ROW_W-1:0] pend_row_q, pend_row_d;

  logic accept;
  logic load;
  logic issue;
  cmd_e cmd;

  assign cmd    = cmd_e'(in_cmd_i);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign load   = (state_q == ST_FRAME) && pend_q && status_i.out_free;
  assign issue  = (state_q == ST_FRAME) && !iss_done_q && (!pend_q || load);

  always_comb begin
    state_d    = state_q;
    iss_row_d  = iss_row_q;
    iss_done_d = iss_done_q;
    pend_d     = pend_q;
    pend_row_d = pend_row_q;
    ctrl_o     = '0;
    in_ready_o = (state_q == ST_IDLE);
    row_o      = iss_row_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_SET:     ctrl_o.wr_one = 1'b1;
            CMD_SET_ALL: ctrl_o.wr_all = 1'b1;
            CMD_READ: begin
              ctrl_o.rd_chan = 1'b1;
              state_d        = ST_READ;
            end
            CMD_UPDATE: begin
              iss_row_d  = ROW_W'(ROWS - 1);
              iss_done_d = 1'b0;
              pend_d     = 1'b0;
              state_d    = ST_FRAME;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (status_i.out_free) begin
          ctrl_o.load_reply = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_FRAME: begin
        // one row read ahead keeps a word per cycle flowing while the output register is free
        ctrl_o.rd_row     = issue;
        ctrl_o.load_frame = load;
        ctrl_o.frame_last = load && (pend_row_q == '0);
        if (issue) begin
          pend_row_d = iss_row_q;
          if (iss_row_q == '0) begin
            iss_done_d = 1'b1;
          end else begin
            iss_row_d = iss_row_q - ROW_W'(1);
          end
        end
        if (issue) begin
          pend_d = 1'b1;
        end else if (load) begin
          pend_d = 1'b0;
        end
        if (load && (pend_row_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_row_q  <= '0;
      iss_done_q <= 1'b0;
      pend_q     <= 1'b0;
      pend_row_q <= '0;
    end else begin
      state_q    <= state_d;
      iss_row_q  <= iss_row_d;
      iss_done_q <= iss_done_d;
      pend_q     <= pend_d;
      pend_row_q <= pend_row_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/lgfp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgfp_datapath #(
  parameter int unsigned NUM_DRIVERS = 1
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [lgfp_pkg::CHAN_W-1:0]           channel_i,
  input  wire logic [lgfp_pkg::LEVEL_W-1:0]          level_i,
  input  wire lgfp_pkg::ctrl_t                       ctrl_i,
  input  wire logic [$clog2(NUM_DRIVERS * 12)-1:0]   row_i,
  output lgfp_pkg::status_t                          status_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [lgfp_pkg::WORD_W-1:0]                out_payload_o,
  output logic                                       out_kind_o,
  output logic                                       out_last_o,
  output logic                                       out_bad_o
);
  import lgfp_pkg::*;

  localparam int unsigned ROWS  = NUM_DRIVERS * (CHANS_PER_DRV / 2);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned TOTAL = NUM_DRIVERS * CHANS_PER_DRV;

  // even channels in one memory, odd channels in the other, one row per pair
  logic [LEVEL_W-1:0] mem_lo [ROWS];
  logic [LEVEL_W-1:0] mem_hi [ROWS];

  // a row half without its valid bit reads as the last set-all level, or zero after reset
  logic [ROWS-1:0]    vld_lo_q, vld_hi_q;
  logic [LEVEL_W-1:0] base_q;

  logic [LEVEL_W-1:0] rd_lo_q, rd_hi_q;
  logic               rd_vlo_q, rd_vhi_q;
  logic               sel_hi_q, bad_q;

  logic               out_valid_q;
  logic [WORD_W-1:0]  out_payload_q;
  logic               out_kind_q, out_last_q, out_bad_q;

  logic               chan_ok;
  logic [ROW_W-1:0]   chan_row;
  logic [ROW_W-1:0]   rd_addr;
  logic               rd_en;
  logic [LEVEL_W-1:0] lo_val, hi_val, reply_val;

  assign chan_ok  = (channel_i < CHAN_W'(TOTAL));
  assign chan_row = channel_i[ROW_W:1];
  assign rd_en    = ctrl_i.rd_chan || ctrl_i.rd_row;
  assign rd_addr  = ctrl_i.rd_chan ? chan_row : row_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_one && chan_ok) begin
      if (channel_i[0]) begin
        mem_hi[chan_row] <= level_i;
      end else begin
        mem_lo[chan_row] <= level_i;
      end
    end
    if (rd_en) begin
      rd_lo_q  <= mem_lo[rd_addr];
      rd_hi_q  <= mem_hi[rd_addr];
      rd_vlo_q <= vld_lo_q[rd_addr];
      rd_vhi_q <= vld_hi_q[rd_addr];
    end
    if (ctrl_i.rd_chan) begin
      sel_hi_q <= channel_i[0];
      bad_q    <= !chan_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_lo_q <= '0;
      vld_hi_q <= '0;
      base_q   <= '0;
    end else if (ctrl_i.wr_all) begin
      vld_lo_q <= '0;
      vld_hi_q <= '0;
      base_q   <= level_i;
    end else if (ctrl_i.wr_one && chan_ok) begin
      if (channel_i[0]) begin
        vld_hi_q[chan_row] <= 1'b1;
      end else begin
        vld_lo_q[chan_row] <= 1'b1;
      end
    end
  end

  assign lo_val    = rd_vlo_q ? rd_lo_q : base_q;
  assign hi_val    = rd_vhi_q ? rd_hi_q : base_q;
  assign reply_val = bad_q ? '0 : (sel_hi_q ? hi_val : lo_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_reply || ctrl_i.load_frame) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_reply) begin
      out_payload_q <= {{(WORD_W - LEVEL_W){1'b0}}, reply_val};
      out_kind_q    <= KIND_REPLY;
      out_last_q    <= 1'b0;
      out_bad_q     <= bad_q;
    end else if (ctrl_i.load_frame) begin
      out_payload_q <= {hi_val, lo_val};
      out_kind_q    <= KIND_FRAME;
      out_last_q    <= ctrl_i.frame_last;
      out_bad_q     <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_payload_o     = out_payload_q;
  assign out_kind_o        = out_kind_q;
  assign out_last_o        = out_last_q;
  assign out_bad_o         = out_bad_q;

endmodule

`default_nettype wire

// ===== src/led_grayscale_frame_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// set and set-all: written as the item is taken; read: the addressed row is registered, then the
// reply is loaded into the output register once it is free; update: NUM_DRIVERS*12 frame words,
// one per cycle while the output register is free, paced by the single read port of the
// paired-channel memories; the next item is taken once the last word is in the output register
// reset is asynchronous and active low; the store reads as zero right after reset (per-channel
// valid bits, no clearing pass)

module led_grayscale_frame_packer #(
  parameter int unsigned NUM_DRIVERS = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // channel [6:0], level [18:7], zero [23:19]
  input  wire logic [1:0]  s_axis_tuser,   // command [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // payload [23:0]
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser    // kind [0], bad_index [1]
);
  import lgfp_pkg::*;

  localparam int unsigned ROW_W = $clog2(NUM_DRIVERS * (CHANS_PER_DRV / 2));

  ctrl_t            ctrl;
  status_t          status;
  logic [ROW_W-1:0] row;
  logic             out_kind, out_bad;

  lgfp_ctrl #(
    .NUM_DRIVERS(NUM_DRIVERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .row_o      (row)
  );

  lgfp_datapath #(
    .NUM_DRIVERS(NUM_DRIVERS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .channel_i     (s_axis_tdata[CHAN_W-1:0]),
    .level_i       (s_axis_tdata[CHAN_W+LEVEL_W-1:CHAN_W]),
    .ctrl_i        (ctrl),
    .row_i         (row),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_payload_o (m_axis_tdata),
    .out_kind_o    (out_kind),
    .out_last_o    (m_axis_tlast),
    .out_bad_o     (out_bad)
  );

  assign m_axis_tuser = {out_bad, out_kind};

endmodule

`default_nettype wire

// ===== src/lgfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "led_grayscale_frame_packer_assert.svh"

module lgfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled word stays put
  `LGFP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output changed while stalled")
  // the latch request only rides on frame words
  `LGFP_IMPLY(a_last_frame, m_axis_tvalid && m_axis_tlast, !m_axis_tuser[0], "tlast on a read reply")
  // a bad index reply carries no level
  `LGFP_IMPLY(a_bad_reply, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] && (m_axis_tdata == 24'd0), "bad index flag on a frame word or nonzero payload")
  // replies hold one 12-bit level
  `LGFP_IMPLY(a_reply_narrow, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[23:12] == 12'd0, "read reply wider than a level")

endmodule

bind led_grayscale_frame_packer lgfp_checker u_lgfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lgfp_pkg::*;

  localparam int unsigned NDRV        = 1;
  localparam int unsigned TOTAL_CHANS = NDRV * CHANS_PER_DRV;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RAND_ITEMS  = 97;

  typedef struct {
    cmd_e             cmd;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
    bit               drain;  // hold off until every pending beat has arrived
  } led_cmd_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] payload;
    logic              last;
    logic              bad_index;
  } frame_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // channel [6:0], level [18:7], zero [23:19]
  logic [1:0]  s_axis_tuser  = '0;  // command [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // payload [23:0]
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;        // kind [0], bad_index [1]

  led_cmd_t           cmd_queue[$];
  frame_beat_t        expected_beats[$];
  logic [LEVEL_W-1:0] level_store[TOTAL_CHANS];

  int unsigned sent_count   = 0;
  int unsigned total_items  = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_count    = 0;
  bit          timed_out    = 1'b0;

  led_grayscale_frame_packer #(
    .NUM_DRIVERS(NDRV)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // idle percentages by phase: sender light / receiver heavy, then swapped, then none
  function automatic int unsigned send_idle_pct();
    if (sent_count < total_items / 3) return 10;
    else if (sent_count < 2 * total_items / 3) return 60;
    else return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (sent_count < total_items / 3) return 60;
    else if (sent_count < 2 * total_items / 3) return 10;
    else return 0;
  endfunction

  task automatic queue_cmd(cmd_e c, int unsigned ch, int unsigned lvl, bit drain);
    led_cmd_t it;
    it.cmd     = c;
    it.channel = ch[CHAN_W-1:0];
    it.level   = lvl[LEVEL_W-1:0];
    it.drain   = drain;
    cmd_queue.push_back(it);
  endtask

  // tracks the channel store and queues the beats each command should produce
  task automatic apply_command(cmd_e c, logic [CHAN_W-1:0] ch, logic [LEVEL_W-1:0] lvl);
    frame_beat_t b;
    case (c)
      CMD_SET: begin
        if (ch < TOTAL_CHANS) level_store[ch] = lvl;
      end
      CMD_SET_ALL: begin
        foreach (level_store[i]) level_store[i] = lvl;
      end
      CMD_UPDATE: begin
        for (int i = TOTAL_CHANS - 1; i >= 1; i -= 2) begin
          b.kind      = KIND_FRAME;
          b.payload   = {level_store[i], level_store[i-1]};
          b.last      = (i == 1);
          b.bad_index = 1'b0;
          expected_beats.push_back(b);
        end
      end
      default: begin
        b.kind = KIND_REPLY;
        b.last = 1'b0;
        if (ch < TOTAL_CHANS) begin
          b.payload   = {{(WORD_W-LEVEL_W){1'b0}}, level_store[ch]};
          b.bad_index = 1'b0;
        end else begin
          b.payload   = '0;
          b.bad_index = 1'b1;
        end
        expected_beats.push_back(b);
      end
    endcase
  endtask

  // driver: holds valid until the transfer, then picks up the next queued command
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        void'(cmd_queue.pop_front());
        sent_count++;
      end
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
          !(cmd_queue[0].drain && (s_axis_tvalid || expected_beats.size() != 0))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cmd_queue[0].level, cmd_queue[0].channel};
        s_axis_tuser  <= cmd_queue[0].cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
  end

  // monitor: checks output transfers, predicts from input transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result: payload %h tlast %b tuser %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          err_count++;
        end else begin
          frame_beat_t e;
          e = expected_beats.pop_front();
          if (m_axis_tuser[0] !== e.kind) begin
            $error("kind: expected %b, got %b", e.kind, m_axis_tuser[0]);
            err_count++;
          end
          if (m_axis_tdata !== e.payload) begin
            $error("payload: expected %h, got %h", e.payload, m_axis_tdata);
            err_count++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %b, got %b", e.last, m_axis_tlast);
            err_count++;
          end
          if (m_axis_tuser[1] !== e.bad_index) begin
            $error("bad_index: expected %b, got %b", e.bad_index, m_axis_tuser[1]);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_command(cmd_e'(s_axis_tuser), s_axis_tdata[6:0], s_axis_tdata[18:7]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned r;
    int unsigned ch;
    int unsigned lvl;
    foreach (level_store[i]) level_store[i] = '0;

    // directed: reset contents, extremes, out-of-range indices, set-all and clear
    queue_cmd(CMD_READ,    0,   0,    1'b0);
    queue_cmd(CMD_READ,    23,  0,    1'b0);
    queue_cmd(CMD_UPDATE,  0,   0,    1'b0);
    queue_cmd(CMD_SET,     0,   4095, 1'b0);
    queue_cmd(CMD_SET,     23,  4095, 1'b0);
    queue_cmd(CMD_SET,     1,   2730, 1'b0);
    queue_cmd(CMD_SET,     22,  1365, 1'b0);
    queue_cmd(CMD_SET,     24,  777,  1'b0);
    queue_cmd(CMD_SET,     127, 1234, 1'b0);
    queue_cmd(CMD_READ,    0,   4095, 1'b0);
    queue_cmd(CMD_READ,    23,  0,    1'b0);
    queue_cmd(CMD_READ,    24,  0,    1'b0);
    queue_cmd(CMD_READ,    127, 4095, 1'b0);
    queue_cmd(CMD_READ,    22,  0,    1'b0);
    queue_cmd(CMD_UPDATE,  127, 4095, 1'b0);
    queue_cmd(CMD_SET_ALL, 127, 4095, 1'b0);
    queue_cmd(CMD_UPDATE,  0,   0,    1'b0);
    queue_cmd(CMD_READ,    5,   0,    1'b0);
    queue_cmd(CMD_SET_ALL, 0,   0,    1'b0);
    queue_cmd(CMD_UPDATE,  0,   0,    1'b0);
    queue_cmd(CMD_SET,     12,  2048, 1'b0);
    queue_cmd(CMD_READ,    12,  0,    1'b1);
    queue_cmd(CMD_UPDATE,  0,   0,    1'b0);

    // random: mostly in-range channels so reads and frames see written data
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r   = $urandom_range(99);
      ch  = ($urandom_range(99) < 80) ? $urandom_range(TOTAL_CHANS - 1) : $urandom_range(127);
      lvl = ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 4095 : 0)
                                     : $urandom_range(4095);
      if (r < 35)      queue_cmd(CMD_SET,     ch, lvl, n == 40 || n == 85);
      else if (r < 43) queue_cmd(CMD_SET_ALL, ch, lvl, n == 40 || n == 85);
      else if (r < 58) queue_cmd(CMD_UPDATE,  ch, lvl, n == 40 || n == 85);
      else             queue_cmd(CMD_READ,    ch, lvl, n == 40 || n == 85);
    end
    total_items = cmd_queue.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        wait (cmd_queue.size() == 0 && !s_axis_tvalid);
        wait (expected_beats.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk_i);
      end
      begin
        wait (stall_cycles >= STALL_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (expected_beats.size() != 0) begin
      $error("%0d expected results never arrived", expected_beats.size());
      err_count++;
    end
    if (timed_out) begin
      $display("led_grayscale_frame_packer regression: fail");
    end else if (err_count == 0) begin
      $display("led_grayscale_frame_packer regression: pass");
    end else begin
      $display("led_grayscale_frame_packer regression: fail");
    end
    $finish;
  end

endmodule

// ===== led_grayscale_frame_packer.f =====
+incdir+src
src/lgfp_pkg.sv
src/lgfp_ctrl.sv
src/lgfp_datapath.sv
src/led_grayscale_frame_packer.sv
src/lgfp_checker.sv
tb/sv/tb.sv
